// ----- sv/owbm_pkg.sv -----
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants for the one-wire bus master: command codes,
// sequencer phases, timing register indexes and reset values, and the
// structs passed between the register file, the sequencer and the top level.
// ----------------------------------------------------------------------------
package owbm_pkg;

  // field widths fixed by the interface
  localparam int OP_W     = 2;
  localparam int DATA_W   = 16;
  localparam int COUNT_W  = 5;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 3;

  // command codes
  localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
  localparam logic [OP_W-1:0] OP_RESET = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  // timing register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_SMP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_REC     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SMP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_REST     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LOW     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_REST    = 3'd7;

  // timing register reset values, in ticks
  localparam logic [CFG_W-1:0] RST_RESET_LOW    = 10'd480;
  localparam logic [CFG_W-1:0] RST_PRESENCE_SMP = 10'd65;
  localparam logic [CFG_W-1:0] RST_RESET_REC    = 10'd415;
  localparam logic [CFG_W-1:0] RST_READ_LOW     = 10'd1;
  localparam logic [CFG_W-1:0] RST_READ_SMP     = 10'd14;
  localparam logic [CFG_W-1:0] RST_READ_REST    = 10'd45;
  localparam logic [CFG_W-1:0] RST_WRITE_LOW    = 10'd10;
  localparam logic [CFG_W-1:0] RST_WRITE_REST   = 10'd50;

  // sequencer phases, one-hot
  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_RST_LOW  = 8'b0000_0010,
    PH_RST_WAIT = 8'b0000_0100,
    PH_RST_REC  = 8'b0000_1000,
    PH_SLOT_LOW = 8'b0001_0000,
    PH_WR_REST  = 8'b0010_0000,
    PH_RD_WAIT  = 8'b0100_0000,
    PH_RD_REST  = 8'b1000_0000
  } phase_t;

  // timing registers as seen by the sequencer
  typedef struct packed {
    logic [CFG_W-1:0] reset_low;
    logic [CFG_W-1:0] presence_smp;
    logic [CFG_W-1:0] reset_rec;
    logic [CFG_W-1:0] read_low;
    logic [CFG_W-1:0] read_smp;
    logic [CFG_W-1:0] read_rest;
    logic [CFG_W-1:0] write_low;
    logic [CFG_W-1:0] write_rest;
  } cfg_t;

  // one tick of input
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [DATA_W-1:0]  write_data;
    logic [COUNT_W-1:0] bit_count;
    logic               line_level;
  } item_t;

  // one tick of result
  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic [DATA_W-1:0] read_data;
    logic              reset_error;
    logic              command_rejected;
  } res_t;

endpackage

// ----- sv/owbm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// owbm_cfg_regs
// Timing register file: eight 10-bit tick counts written through a plain
// write port, presented to the sequencer as one struct.
// ----------------------------------------------------------------------------
module owbm_cfg_regs import owbm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESET_LOW:    cfg_nxt.reset_low    = cfg_wdata;
        CFG_PRESENCE_SMP: cfg_nxt.presence_smp = cfg_wdata;
        CFG_RESET_REC:    cfg_nxt.reset_rec    = cfg_wdata;
        CFG_READ_LOW:     cfg_nxt.read_low     = cfg_wdata;
        CFG_READ_SMP:     cfg_nxt.read_smp     = cfg_wdata;
        CFG_READ_REST:    cfg_nxt.read_rest    = cfg_wdata;
        CFG_WRITE_LOW:    cfg_nxt.write_low    = cfg_wdata;
        CFG_WRITE_REST:   cfg_nxt.write_rest   = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  // register storage with reset defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low    <= RST_RESET_LOW;
      cfg_r.presence_smp <= RST_PRESENCE_SMP;
      cfg_r.reset_rec    <= RST_RESET_REC;
      cfg_r.read_low     <= RST_READ_LOW;
      cfg_r.read_smp     <= RST_READ_SMP;
      cfg_r.read_rest    <= RST_READ_REST;
      cfg_r.write_low    <= RST_WRITE_LOW;
      cfg_r.write_rest   <= RST_WRITE_REST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/owbm_core.sv -----
// ----------------------------------------------------------------------------
// owbm_core
// Bus sequencer: advances one tick per step, runs the reset, write-slot and
// read-slot timing, shifts data LSB first and forms the result of the tick.
// ----------------------------------------------------------------------------
module owbm_core import owbm_pkg::*; #(
  parameter int MAX_BITS          = 16,
  parameter int TICK_COUNTER_BITS = 10
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step_en,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  localparam int BLW  = $clog2(MAX_BITS + 1);
  localparam int IDXW = $clog2(MAX_BITS);
  localparam int NB   = (MAX_BITS < DATA_W) ? MAX_BITS : DATA_W;
  localparam int CW   = ((TICK_COUNTER_BITS > CFG_W) ? TICK_COUNTER_BITS : CFG_W) + 1;
  localparam int SATW = COUNT_W + 1;
  localparam logic [SATW-1:0] MAX_BITS_SAT = SATW'(MAX_BITS);

  // sequencer state
  phase_t                       phase_r, phase_nxt;
  logic [TICK_COUNTER_BITS-1:0] cnt_r, cnt_nxt;
  logic [BLW-1:0]               bits_left_r, bits_left_nxt;
  logic [BLW-1:0]               bit_total_r, bit_total_nxt;
  logic [MAX_BITS-1:0]          shift_r, shift_nxt;
  logic [OP_W-1:0]              kind_r, kind_nxt;
  logic                         err_r, err_nxt;

  // values seen by this tick, after a possible command start
  logic                         start;
  phase_t                       phase_cur;
  logic [TICK_COUNTER_BITS-1:0] cnt_cur;
  logic [BLW-1:0]               bits_left_cur;
  logic [BLW-1:0]               bit_total_cur;
  logic [MAX_BITS-1:0]          shift_cur;
  logic [OP_W-1:0]              kind_cur;
  logic                         err_cur;
  logic [SATW-1:0]              count_sat;
  logic [MAX_BITS-1:0]          wdata_ext;

  logic [CFG_W-1:0]             part_len;
  logic [CFG_W-1:0]             part_len_n;
  logic                         part_end;
  logic [TICK_COUNTER_BITS-1:0] cnt_step;
  logic [BLW-1:0]               idx_diff;
  logic [IDXW-1:0]              bit_idx;
  logic [BLW-1:0]               bits_dec;

  // command start: load the transfer on the first tick
  always_comb begin
    start     = (phase_r == PH_IDLE) && (item.op != OP_NONE);
    count_sat = {1'b0, item.bit_count};
    if (count_sat == '0) begin
      count_sat = SATW'(1);
    end else if (count_sat > MAX_BITS_SAT) begin
      count_sat = MAX_BITS_SAT;
    end
    wdata_ext           = '0;
    wdata_ext[NB-1:0]   = item.write_data[NB-1:0];

    phase_cur     = phase_r;
    cnt_cur       = cnt_r;
    bits_left_cur = bits_left_r;
    bit_total_cur = bit_total_r;
    shift_cur     = shift_r;
    kind_cur      = kind_r;
    err_cur       = err_r;
    if (start) begin
      kind_cur = item.op;
      cnt_cur  = '0;
      err_cur  = 1'b0;
      if (item.op == OP_RESET) begin
        phase_cur = PH_RST_LOW;
      end else begin
        bit_total_cur = BLW'(count_sat);
        bits_left_cur = BLW'(count_sat);
        shift_cur     = (item.op == OP_WRITE) ? wdata_ext : '0;
        phase_cur     = PH_SLOT_LOW;
      end
    end
  end

  // length of the current part of the slot
  always_comb begin
    unique case (phase_cur)
      PH_RST_LOW:  part_len = cfg.reset_low;
      PH_RST_WAIT: part_len = cfg.presence_smp;
      PH_RST_REC:  part_len = cfg.reset_rec;
      PH_SLOT_LOW: part_len = (kind_cur == OP_WRITE) ? cfg.write_low : cfg.read_low;
      PH_WR_REST:  part_len = cfg.write_rest;
      PH_RD_WAIT:  part_len = cfg.read_smp;
      PH_RD_REST:  part_len = cfg.read_rest;
      default:     part_len = CFG_W'(1);
    endcase
  end

  // tick counter compare, a zero length lasts one tick
  assign part_len_n = (part_len == '0) ? CFG_W'(1) : part_len;
  assign part_end   = (CW'(cnt_cur) + CW'(1)) >= CW'(part_len_n);
  assign cnt_step   = part_end ? '0 : cnt_cur + TICK_COUNTER_BITS'(1);
  assign idx_diff   = bit_total_cur - bits_left_cur;
  assign bit_idx    = idx_diff[IDXW-1:0];
  assign bits_dec   = bits_left_cur - BLW'(1);

  // phase sequencing and result of this tick
  always_comb begin
    phase_nxt     = phase_cur;
    cnt_nxt       = cnt_cur;
    bits_left_nxt = bits_left_cur;
    bit_total_nxt = bit_total_cur;
    shift_nxt     = shift_cur;
    kind_nxt      = kind_cur;
    err_nxt       = err_cur;

    res                  = '0;
    res.busy_res         = (phase_cur != PH_IDLE);
    res.command_rejected = (phase_r != PH_IDLE) && (item.op != OP_NONE);

    unique case (phase_cur)
      PH_IDLE: begin
        phase_nxt = PH_IDLE;
      end
      PH_RST_LOW: begin
        res.drive_low = 1'b1;
        cnt_nxt       = cnt_step;
        if (part_end) phase_nxt = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        cnt_nxt = cnt_step;
        if (part_end) begin
          // line high at the sample means no presence pulse
          err_nxt   = item.line_level;
          phase_nxt = PH_RST_REC;
        end
      end
      PH_RST_REC: begin
        cnt_nxt = cnt_step;
        if (part_end) begin
          // line still low here means a shorted bus
          err_nxt         = err_cur | ~item.line_level;
          res.done_res    = 1'b1;
          res.reset_error = err_nxt;
          phase_nxt       = PH_IDLE;
        end
      end
      PH_SLOT_LOW: begin
        res.drive_low = 1'b1;
        cnt_nxt       = cnt_step;
        if (part_end) phase_nxt = (kind_cur == OP_WRITE) ? PH_WR_REST : PH_RD_WAIT;
      end
      PH_WR_REST: begin
        res.drive_low = ~shift_cur[bit_idx];
        cnt_nxt       = cnt_step;
        if (part_end) begin
          bits_left_nxt = bits_dec;
          if (bits_dec == '0) begin
            res.done_res = 1'b1;
            phase_nxt    = PH_IDLE;
          end else begin
            phase_nxt = PH_SLOT_LOW;
          end
        end
      end
      PH_RD_WAIT: begin
        cnt_nxt = cnt_step;
        if (part_end) begin
          if (item.line_level) shift_nxt[bit_idx] = 1'b1;
          phase_nxt = PH_RD_REST;
        end
      end
      PH_RD_REST: begin
        cnt_nxt = cnt_step;
        if (part_end) begin
          bits_left_nxt = bits_dec;
          if (bits_dec == '0) begin
            res.done_res            = 1'b1;
            res.read_data[NB-1:0]   = shift_cur[NB-1:0];
            phase_nxt               = PH_IDLE;
          end else begin
            phase_nxt = PH_SLOT_LOW;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // state registers, advanced once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      bits_left_r <= '0;
      bit_total_r <= '0;
      shift_r     <= '0;
      kind_r      <= OP_NONE;
      err_r       <= 1'b0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      bits_left_r <= bits_left_nxt;
      bit_total_r <= bit_total_nxt;
      shift_r     <= shift_nxt;
      kind_r      <= kind_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

// ----- sv/one_wire_bus_master.sv -----
// ----------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master driven by a microsecond tick stream.
// ----------------------------------------------------------------------------
// Each input transaction is one bus tick carrying an optional command and the
// sampled line level; each produces exactly one result transaction with the
// line drive for that tick and the command status. One tick is taken per
// clock cycle, every cycle, as long as the result side keeps up; a tick goes
// through an input register and the sequencer into a result register.
// Timing registers are eight 10-bit tick counts, which must be written only
// while the master is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module one_wire_bus_master import owbm_pkg::*; #(
  parameter int MAX_BITS          = 16,
  parameter int TICK_COUNTER_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // tick input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_op,
  input  logic [DATA_W-1:0]    in_write_data,
  input  logic [COUNT_W-1:0]   in_bit_count,
  input  logic                 in_line_level,
  // tick result
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_drive_low,
  output logic                 out_busy_res,
  output logic                 out_done_res,
  output logic [DATA_W-1:0]    out_read_data,
  output logic                 out_reset_error,
  output logic                 out_command_rejected
);

  cfg_t  cfg;
  item_t item_r;
  logic  in_valid_r;
  logic  out_valid_r;
  res_t  res;
  res_t  res_r;
  logic  out_hold;
  logic  step_en;
  logic  in_take;

  // handshake: the result register drains every cycle the far side allows
  assign out_hold = out_valid_r && out_stall;
  assign step_en  = in_valid_r && !out_hold;
  assign in_stall = in_valid_r && out_hold;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (step_en) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.op         <= in_op;
      item_r.write_data <= in_write_data;
      item_r.bit_count  <= in_bit_count;
      item_r.line_level <= in_line_level;
    end
  end

  // timing registers
  owbm_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // bus sequencer
  owbm_core #(
    .MAX_BITS          (MAX_BITS),
    .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_drive_low        = res_r.drive_low;
  assign out_busy_res         = res_r.busy_res;
  assign out_done_res         = res_r.done_res;
  assign out_read_data        = res_r.read_data;
  assign out_reset_error      = res_r.reset_error;
  assign out_command_rejected = res_r.command_rejected;

  // every tick leaving the input register shows up as a result
  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_valid_r)
    else $error("tick consumed without a result");

  // a reset error is reported only on the completing tick
  a_error_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_reset_error) |-> (out_done_res && out_busy_res))
    else $error("reset error outside a completing tick");

  // read data stays zero except on a completing tick
  a_rdata_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_read_data != '0)) |-> out_done_res)
    else $error("read data outside a completing tick");

  // a rejected command can only happen during a command
  a_reject_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_command_rejected) |-> out_busy_res)
    else $error("command rejected while idle");

endmodule
